// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the RTL. Each expects clk and rst_n
// in scope and is quiet while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mwga_pkg.sv =====
// ---------------------------------------------------------------------------
// mwga_pkg
// Shared types, register map, waveform codes and the sine ROM builder for
// the accumulate-style multi-waveform generator.
// ---------------------------------------------------------------------------
package mwga_pkg;

    // Sample and register widths
    localparam int SAMPLE_W    = 32;
    localparam int PHASE_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    // Default build parameters
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int SINE_BITS_DEF        = 18;

    // Register map
    localparam logic [CFG_INDEX_W-1:0] REG_WAVEFORM    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_PHASE = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_AMPLITUDE   = 3'd3;

    localparam logic signed [SAMPLE_W-1:0] AMPLITUDE_RESET = 32'sd65536;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_SAWTOOTH = 2'd3
    } waveform_t;

    // Settings the datapath reads
    typedef struct packed {
        waveform_t                   waveform;
        logic signed [SAMPLE_W-1:0]  amplitude;
    } cfg_t;

    // Angles in Q30 radians for the ROM builder
    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] PI_Q30      = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam int          SERIES_TERMS = 12;

    // sin(a) for a in [0, pi/2], Q30 in and out; elaboration only
    function automatic logic [63:0] sine_q30(input logic [63:0] a);
        logic [63:0]        a2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        a2   = (a * a) >> 30;
        term = a;
        sum  = signed'(a);
        for (int n = 1; n <= SERIES_TERMS; n++)
        begin
            term = ((term * a2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n[0])
                sum = sum - signed'(term);
            else
                sum = sum + signed'(term);
        end
        if (sum < 0)
            sum = '0;
        if (unsigned'(sum) > ONE_Q30)
            sum = signed'(ONE_Q30);
        return unsigned'(sum);
    endfunction

    // One ROM entry in Q1.(bits-1) for an angle in Q30 over [0, 2pi)
    function automatic logic signed [31:0] sine_entry(input logic [63:0] ang,
                                                      input int unsigned bits);
        logic [63:0] a;
        logic [63:0] full;
        logic [63:0] mag;
        logic        neg;
        a    = ang;
        neg  = 1'b0;
        full = (64'd1 << (bits - 1)) - 64'd1;
        if (a >= PI_Q30)
        begin
            neg = 1'b1;
            a   = a - PI_Q30;
        end
        if (a > HALF_PI_Q30)
            a = (a > PI_Q30) ? 64'd0 : PI_Q30 - a;
        mag = (sine_q30(a) * full + (64'd1 << 29)) >> 30;
        return neg ? -signed'(mag[31:0]) : signed'(mag[31:0]);
    endfunction

endpackage

// ===== rtl/mwga_stream_if.sv =====
// ---------------------------------------------------------------------------
// mwga_stream_if
// Valid/ready stream interfaces for input and result words.
// ---------------------------------------------------------------------------

// Input word: sample plus end-of-run flag
interface mwga_in_if import mwga_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  in_sample;
    logic                        last_in;

    modport source (output valid, in_sample, last_in, input ready);
    modport sink   (input valid, in_sample, last_in, output ready);
endinterface

// Result word: summed sample plus end-of-run flag
interface mwga_out_if import mwga_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  out_sample;
    logic                        last_out;

    modport source (output valid, out_sample, last_out, input ready);
    modport sink   (input valid, out_sample, last_out, output ready);
endinterface

// ===== rtl/mwga_cfg_phase.sv =====
// ---------------------------------------------------------------------------
// mwga_cfg_phase
// Configuration registers and the phase accumulator, which steps backward
// once per accepted word and reloads after the last word of a run.
// ---------------------------------------------------------------------------
module mwga_cfg_phase import mwga_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  logic [CFG_INDEX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0]   wr_data,
    input  logic                    fire,
    input  logic                    last,
    output cfg_t                    cfg,
    output logic [PHASE_W-1:0]      phase,
    output logic [PHASE_W-1:0]      start_phase
);

    waveform_t                   waveform_reg;
    logic [PHASE_W-1:0]          step_reg;
    logic [PHASE_W-1:0]          start_reg;
    logic signed [SAMPLE_W-1:0]  amp_reg;
    logic [PHASE_W-1:0]          phase_reg;
    logic [PHASE_W-1:0]          phase_next;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= WAVE_SINE;
            step_reg     <= '0;
            start_reg    <= '0;
            amp_reg      <= AMPLITUDE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_WAVEFORM:    waveform_reg <= waveform_t'(wr_data[1:0]);
                REG_PHASE_STEP:  step_reg     <= wr_data[PHASE_W-1:0];
                REG_START_PHASE: start_reg    <= wr_data[PHASE_W-1:0];
                REG_AMPLITUDE:   amp_reg      <= signed'(wr_data[SAMPLE_W-1:0]);
                default:         ;
            endcase
        end
    end

    // Phase: load on start write, reload after last, else step back
    always_comb
    begin
        phase_next = phase_reg;
        if (wr_en && wr_index == REG_START_PHASE)
            phase_next = wr_data[PHASE_W-1:0];
        else if (fire)
            phase_next = last ? start_reg : phase_reg - step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else
            phase_reg <= phase_next;
    end

    assign cfg.waveform  = waveform_reg;
    assign cfg.amplitude = amp_reg;
    assign phase         = phase_reg;
    assign start_phase   = start_reg;

endmodule

// ===== rtl/mwga_sine_rom.sv =====
// ---------------------------------------------------------------------------
// mwga_sine_rom
// One full sine cycle, SINE_TABLE_DEPTH entries in Q1.(SINE_BITS-1),
// built at elaboration, with a registered read port.
// ---------------------------------------------------------------------------
module mwga_sine_rom import mwga_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int SINE_BITS        = SINE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]   addr,
    output logic signed [SINE_BITS-1:0]           data
);

    logic signed [SINE_BITS-1:0] rom [SINE_TABLE_DEPTH];
    logic signed [SINE_BITS-1:0] data_reg;

    // Table contents, angle of entry k rounded to Q30
    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_tbl
        localparam logic [63:0] Ang =
            (TWO_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        localparam logic signed [31:0] Ent = sine_entry(Ang, SINE_BITS);
        assign rom[k] = Ent[SINE_BITS-1:0];
    end

    // Registered read, held while the stage stalls
    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= rom[addr];
    end

    assign data = data_reg;

endmodule

// ===== rtl/mwga_pipe.sv =====
// ---------------------------------------------------------------------------
// mwga_pipe
// Five-stage datapath: capture, ROM index and non-sine waves, ROM read,
// amplitude multiply, round/add/saturate into the output register.
// Each stage advances when it is empty or the stage after it moves.
// ---------------------------------------------------------------------------
module mwga_pipe import mwga_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int SINE_BITS        = SINE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic [PHASE_W-1:0]  phase,
    mwga_in_if.sink             in_ch,
    mwga_out_if.source          out_ch
);

    localparam int IW = $clog2(SINE_TABLE_DEPTH);
    localparam int PW = PHASE_W + IW + 1;
    localparam int MW = SAMPLE_W + SINE_BITS - 1;
    localparam int NS = 5;

    logic [NS-1:0]               vld_reg;
    logic [NS-1:0]               ce;

    logic signed [SAMPLE_W-1:0]  s1_sample_reg;
    logic                        s1_last_reg;
    logic [PHASE_W-1:0]          s1_phase_reg;

    logic [IW-1:0]               s2_idx_reg;
    logic signed [SAMPLE_W:0]    s2_alt_reg;
    logic signed [SAMPLE_W-1:0]  s2_sample_reg;
    logic                        s2_last_reg;

    logic signed [SINE_BITS-1:0] s3_rom;
    logic signed [SAMPLE_W:0]    s3_alt_reg;
    logic signed [SAMPLE_W-1:0]  s3_sample_reg;
    logic                        s3_last_reg;

    logic [MW-1:0]               s4_prod_reg;
    logic                        s4_neg_reg;
    logic signed [SAMPLE_W:0]    s4_alt_reg;
    logic signed [SAMPLE_W-1:0]  s4_sample_reg;
    logic                        s4_last_reg;

    logic signed [SAMPLE_W-1:0]  out_sample_reg;
    logic                        out_last_reg;

    // Stage enables, back from the output
    always_comb
    begin
        ce[NS-1] = !vld_reg[NS-1] || out_ch.ready;
        for (int k = NS - 2; k >= 0; k--)
            ce[k] = !vld_reg[k] || ce[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (ce[0])
                vld_reg[0] <= in_ch.valid;
            for (int k = 1; k < NS; k++)
            begin
                if (ce[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign in_ch.ready = ce[0];

    // Stage 1: capture word and current phase
    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            s1_sample_reg <= in_ch.in_sample;
            s1_last_reg   <= in_ch.last_in;
            s1_phase_reg  <= phase;
        end
    end

    // Stage 2: rounded table index and the non-sine waves
    logic [PW-1:0]            idx_sum;
    logic [IW:0]              idx_full;
    logic [IW-1:0]            idx;
    logic signed [SAMPLE_W:0] amp_x;
    logic signed [SAMPLE_W:0] square_w;
    logic [PHASE_W-1:0]       saw_u;
    logic [PHASE_W:0]         saw_r;
    logic signed [SAMPLE_W:0] saw_w;
    logic [PHASE_W:0]         tri_mag;
    logic [PHASE_W:0]         tri_r;
    logic signed [SAMPLE_W:0] tri_w;
    logic signed [SAMPLE_W:0] alt_w;

    always_comb
    begin
        idx_sum  = PW'(s1_phase_reg) * PW'(SINE_TABLE_DEPTH) + PW'(64'h8000_0000);
        idx_full = idx_sum[PW-1:PHASE_W];
        idx      = (idx_full >= (IW+1)'(SINE_TABLE_DEPTH)) ? '0 : idx_full[IW-1:0];

        amp_x    = {cfg.amplitude[SAMPLE_W-1], cfg.amplitude};
        square_w = (s1_phase_reg != '0 && !s1_phase_reg[PHASE_W-1]) ? amp_x : -amp_x;

        // x - floor(x + 1/2), rounded to Q16.16 with ties up
        saw_u = s1_phase_reg + 32'h8000_0000;
        saw_r = {1'b0, saw_u} + 33'h0_0000_8000;
        saw_w = signed'({16'b0, saw_r[PHASE_W:16]}) - 33'sd32768;

        tri_mag = s1_phase_reg[PHASE_W-1] ? (33'h1_0000_0000 - {1'b0, s1_phase_reg})
                                          : {1'b0, s1_phase_reg};
        tri_r   = tri_mag + 33'h0_0000_8000;
        tri_w   = signed'({16'b0, tri_r[PHASE_W:16]});

        case (cfg.waveform)
            WAVE_TRIANGLE: alt_w = tri_w;
            WAVE_SQUARE:   alt_w = square_w;
            WAVE_SAWTOOTH: alt_w = saw_w;
            default:       alt_w = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            s2_idx_reg    <= idx;
            s2_alt_reg    <= alt_w;
            s2_sample_reg <= s1_sample_reg;
            s2_last_reg   <= s1_last_reg;
        end
    end

    // Stage 3: table read
    mwga_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SINE_BITS        (SINE_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (ce[2]),
        .addr (s2_idx_reg),
        .data (s3_rom)
    );

    always_ff @(posedge clk)
    begin
        if (ce[2])
        begin
            s3_alt_reg    <= s2_alt_reg;
            s3_sample_reg <= s2_sample_reg;
            s3_last_reg   <= s2_last_reg;
        end
    end

    // Stage 4: magnitude multiply
    logic [SAMPLE_W-1:0]    amag;
    logic [SINE_BITS-1:0]   e_abs;
    logic [SINE_BITS-2:0]   emag;

    always_comb
    begin
        amag  = cfg.amplitude[SAMPLE_W-1] ? unsigned'(-cfg.amplitude)
                                          : unsigned'(cfg.amplitude);
        e_abs = s3_rom[SINE_BITS-1] ? unsigned'(-s3_rom) : unsigned'(s3_rom);
        emag  = e_abs[SINE_BITS-2:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce[3])
        begin
            s4_prod_reg   <= MW'(amag) * MW'(emag);
            s4_neg_reg    <= cfg.amplitude[SAMPLE_W-1] ^ s3_rom[SINE_BITS-1];
            s4_alt_reg    <= s3_alt_reg;
            s4_sample_reg <= s3_sample_reg;
            s4_last_reg   <= s3_last_reg;
        end
    end

    // Stage 5: round half away from zero, add, saturate
    logic [MW:0]               rnd;
    logic [SAMPLE_W:0]         rmag;
    logic signed [SAMPLE_W:0]  sine_w;
    logic signed [SAMPLE_W:0]  wave_w;
    logic signed [SAMPLE_W+1:0] sum;
    logic signed [SAMPLE_W-1:0] sat;

    always_comb
    begin
        rnd    = (MW+1)'(s4_prod_reg) + ((MW+1)'(1) << (SINE_BITS - 2));
        rmag   = rnd[MW:SINE_BITS-1];
        sine_w = s4_neg_reg ? -signed'(rmag) : signed'(rmag);
        wave_w = (cfg.waveform == WAVE_SINE) ? sine_w : s4_alt_reg;
        sum    = {{2{s4_sample_reg[SAMPLE_W-1]}}, s4_sample_reg}
               + {wave_w[SAMPLE_W], wave_w};
        if (sum[SAMPLE_W+1:SAMPLE_W-1] == 3'b000 || sum[SAMPLE_W+1:SAMPLE_W-1] == 3'b111)
            sat = sum[SAMPLE_W-1:0];
        else if (sum[SAMPLE_W+1])
            sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end

    always_ff @(posedge clk)
    begin
        if (ce[4])
        begin
            out_sample_reg <= sat;
            out_last_reg   <= s4_last_reg;
        end
    end

    assign out_ch.valid      = vld_reg[NS-1];
    assign out_ch.out_sample = out_sample_reg;
    assign out_ch.last_out   = out_last_reg;

endmodule

// ===== rtl/multi_waveform_generator_accumulate_unit.sv =====
// ---------------------------------------------------------------------------
// multi_waveform_generator_accumulate_unit
// Adds a sine, triangle, square or sawtooth wave onto a sample stream.
// ---------------------------------------------------------------------------
// Usage:
//   sample_in carries one signed Q16.16 word per handshake plus last_in.
//   sample_out returns the word with the wave added (saturated) and
//   last_out copied through, one result per input, in order.
//   The phase accumulator steps back by phase_step after each word and
//   reloads start_phase after a word marked last_in; a start_phase write
//   loads it at once. Configure only while the block is empty.
// Stages: one register each for capture, index, table read, multiply,
//   sum/saturate.
// Throughput: one word per cycle except during a stall; ROM read and
//   multiply have own stages. Stall: every stage holds when the one after
//   it is full and not moving, so sample_in.ready drops only once all five
//   stages are occupied and sample_out is stalled. Bubbles are squeezed out during a stall.
// Reset: pipeline empties, registers return to their reset values
//   (amplitude 1.0, sine, zero step and start phase), phase is zero.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module multi_waveform_generator_accumulate_unit import mwga_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int SINE_BITS        = SINE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    mwga_in_if.sink                 sample_in,
    mwga_out_if.source              sample_out,
    input  logic                    wr_en,
    input  logic [CFG_INDEX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0]   wr_data
);

    cfg_t                cfg;
    logic [PHASE_W-1:0]  phase;
    logic [PHASE_W-1:0]  start_phase;
    logic                in_fire;
    logic                start_wr;
    logic                last_fire;
    logic                out_stall;

    assign in_fire = sample_in.valid && sample_in.ready;

    // Registers and phase accumulator
    mwga_cfg_phase u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .fire        (in_fire),
        .last        (sample_in.last_in),
        .cfg         (cfg),
        .phase       (phase),
        .start_phase (start_phase)
    );

    // Datapath
    mwga_pipe #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SINE_BITS        (SINE_BITS)
    ) u_pipe (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .phase  (phase),
        .in_ch  (sample_in),
        .out_ch (sample_out)
    );

    // Checks
    assign start_wr  = wr_en && wr_index == REG_START_PHASE;
    assign last_fire = in_fire && sample_in.last_in && !wr_en;
    assign out_stall = sample_out.valid && !sample_out.ready;

    `ASSERT_NXT(a_phase_hold, !in_fire && !start_wr, $stable(phase), "phase moved while idle")
    `ASSERT_NXT(a_phase_reload, last_fire, phase == start_phase, "no reload after last word")
    `ASSERT_IMP(a_stall_cause, !sample_in.ready, out_stall, "stall without backpressure")

endmodule
